[rtl/flpa_pkg.sv]
// ----------------------------------------------------------------------------
// flpa_pkg
// Shared types and constants for the free-list page allocator: request and
// response payloads, request modes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package flpa_pkg;

  // Parameter defaults
  localparam int FREE_DEPTH_DEF = 1024;
  localparam int PAGE_BITS_DEF  = 32;

  // Fixed payload field widths
  localparam int PAGE_NUM_W = 32;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;

  // Page count after reset: header page and list page
  localparam int RESET_PAGE_COUNT = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_HEADER    = 3'd1,
    ST_RANGE     = 3'd2,
    ST_FULL      = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

  // Input transaction
  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [PAGE_NUM_W-1:0] page_number;
  } in_req_t;

  // Result transaction
  typedef struct packed {
    logic [PAGE_NUM_W-1:0] granted_page;
    logic [STATUS_W-1:0]   status;
  } out_resp_t;

  // Decision from the control unit for one request
  typedef struct packed {
    logic                  from_stack;  // granted page comes from the stack read
    logic [PAGE_NUM_W-1:0] granted;
    status_t               status;
  } flpa_resp_t;

endpackage : flpa_pkg

`default_nettype wire

[rtl/flpa_stack_mem.sv]
// ----------------------------------------------------------------------------
// flpa_stack_mem
// Free-page stack storage: one write port, one read port, registered read
// data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module flpa_stack_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : flpa_stack_mem

`default_nettype wire

[rtl/flpa_ctrl.sv]
// ----------------------------------------------------------------------------
// flpa_ctrl
// Allocator control: holds the page count and the stack fill level, decides
// each request and issues the stack push or pop in the cycle it is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module flpa_ctrl #(
  parameter int FREE_DEPTH = flpa_pkg::FREE_DEPTH_DEF,
  parameter int PAGE_BITS  = flpa_pkg::PAGE_BITS_DEF,
  parameter int AW         = $clog2(FREE_DEPTH),
  parameter int FW         = $clog2(FREE_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire flpa_pkg::in_req_t             req,
  output logic                               mem_wr_en,
  output logic [AW-1:0]                      mem_wr_addr,
  output logic [flpa_pkg::PAGE_NUM_W-1:0]    mem_wr_data,
  output logic                               mem_rd_en,
  output logic [AW-1:0]                      mem_rd_addr,
  output flpa_pkg::flpa_resp_t               resp
);

  import flpa_pkg::*;

  // Compare width covers both the page field and the page count
  localparam int CW = (PAGE_BITS > PAGE_NUM_W) ? PAGE_BITS : PAGE_NUM_W;
  localparam logic [CW-1:0] PMASK = CW'({PAGE_BITS{1'b1}});
  localparam logic [FW-1:0] FULL_FILL = FW'(FREE_DEPTH);

  logic [PAGE_BITS-1:0] page_count_r, page_count_nxt;
  logic [FW-1:0]        stack_fill_r, stack_fill_nxt;

  logic [CW-1:0] page_x;
  logic [CW-1:0] count_x;
  logic [FW-1:0] fill_dec;
  logic          push, pop;

  assign page_x   = CW'(req.page_number);
  assign count_x  = CW'(page_count_r);
  assign fill_dec = stack_fill_r - FW'(1);

  // Request decision
  always_comb begin
    page_count_nxt  = page_count_r;
    stack_fill_nxt  = stack_fill_r;
    push            = 1'b0;
    pop             = 1'b0;
    resp.from_stack = 1'b0;
    resp.granted    = req.page_number;
    resp.status     = ST_OK;

    unique case (mode_t'(req.mode))
      MODE_ALLOC: begin
        if (stack_fill_r != '0) begin
          pop             = 1'b1;
          stack_fill_nxt  = fill_dec;
          resp.from_stack = 1'b1;
        end else if (count_x == PMASK) begin
          resp.granted = '0;
          resp.status  = ST_EXHAUSTED;
        end else begin
          resp.granted   = PAGE_NUM_W'(count_x);
          page_count_nxt = page_count_r + PAGE_BITS'(1);
        end
      end
      MODE_FREE: begin
        if (req.page_number == '0) begin
          resp.status = ST_HEADER;
        end else if (page_x >= count_x) begin
          resp.status = ST_RANGE;
        end else if (stack_fill_r == FULL_FILL) begin
          resp.status = ST_FULL;
        end else begin
          push           = 1'b1;
          stack_fill_nxt = stack_fill_r + FW'(1);
        end
      end
      MODE_WRITE: begin
        if (page_x >= PMASK) begin
          resp.status = ST_RANGE;
        end else if (page_x >= count_x) begin
          page_count_nxt = PAGE_BITS'(page_x + CW'(1));
        end
      end
      MODE_READ: begin
        if (page_x >= count_x) begin
          resp.status = ST_RANGE;
        end
      end
      default: begin
        resp.status = ST_OK;
      end
    endcase
  end

  // Stack port commands
  assign mem_wr_en   = fire & push;
  assign mem_wr_addr = stack_fill_r[AW-1:0];
  assign mem_wr_data = req.page_number;
  assign mem_rd_en   = fire & pop;
  assign mem_rd_addr = fill_dec[AW-1:0];

  // Count and fill registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= PAGE_BITS'(RESET_PAGE_COUNT);
      stack_fill_r <= '0;
    end else if (fire) begin
      page_count_r <= page_count_nxt;
      stack_fill_r <= stack_fill_nxt;
    end
  end

endmodule : flpa_ctrl

`default_nettype wire

[rtl/free_list_page_allocator.sv]
// ----------------------------------------------------------------------------
// free_list_page_allocator
// LIFO free-list page allocator: page count plus a stack of freed pages.
// A result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless out_ready stalls; a pop reads the
// stack memory in the accept cycle; its registered read data feeds the result.
// Reset (rst_n, synchronous): page count 2, stack empty, no result pending.
// Stack contents are not cleared; entries are only read after being pushed.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_page_allocator #(
  parameter int FREE_DEPTH = flpa_pkg::FREE_DEPTH_DEF,
  parameter int PAGE_BITS  = flpa_pkg::PAGE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire flpa_pkg::in_req_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output flpa_pkg::out_resp_t      out_data
);

  import flpa_pkg::*;

  localparam int AW = $clog2(FREE_DEPTH);
  localparam int FW = $clog2(FREE_DEPTH + 1);

  logic                  fire;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [PAGE_NUM_W-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [PAGE_NUM_W-1:0] mem_rd_data;
  flpa_resp_t            resp;

  logic       out_valid_r, out_valid_nxt;
  flpa_resp_t resp_r;

  // Take a request whenever the result register is free or draining
  assign in_ready = ~out_valid_r | out_ready;
  assign fire     = in_valid & in_ready;

  flpa_ctrl #(
    .FREE_DEPTH (FREE_DEPTH),
    .PAGE_BITS  (PAGE_BITS),
    .AW         (AW),
    .FW         (FW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .req         (in_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .resp        (resp)
  );

  flpa_stack_mem #(
    .DEPTH (FREE_DEPTH),
    .WIDTH (PAGE_NUM_W),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; stack read data holds until the next pop is accepted
  always_ff @(posedge clk) begin
    if (fire) begin
      resp_r <= resp;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.granted_page = resp_r.from_stack ? mem_rd_data : resp_r.granted;
  assign out_data.status       = resp_r.status;

endmodule : free_list_page_allocator

`default_nettype wire

[tb/free_list_page_allocator_tb.sv]
// ----------------------------------------------------------------------------
// free_list_page_allocator_tb
// Self-checking bench for the free-list page allocator. A directed table walks
// the header, range, duplicate-free and exhaustion cases. Random request
// mixes and a stack-fill run follow, all scored against an in-bench model of
// the page count and the free stack. Both sides throttle at random, with two
// long output hold-offs and two full drains.
// ----------------------------------------------------------------------------

module free_list_page_allocator_tb;
  import flpa_pkg::*;

  localparam int HEAD_ROWS    = 24;
  localparam int ALL_ROWS     = 34;
  localparam int MIX_A_ITEMS  = 200;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam logic [PAGE_NUM_W-1:0] PAGE_MAX = '1;

  typedef enum int {RX_STREAM, RX_RANDOM, RX_THROTTLE} rx_style_t;

  // One row of the directed table; has_exp marks a hand-written expectation
  typedef struct packed {
    mode_t                 mode;
    logic [PAGE_NUM_W-1:0] page;
    logic                  has_exp;
    logic [PAGE_NUM_W-1:0] grant;
    status_t               status;
  } step_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_req_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_resp_t out_data;

  // Allocator model state
  logic [PAGE_NUM_W-1:0] free_pages [FREE_DEPTH_DEF];
  int unsigned           free_fill = 0;
  logic [PAGE_NUM_W-1:0] page_count = RESET_PAGE_COUNT;

  out_resp_t pending_grants [$];
  int        errors = 0;
  int        burst_left = 0;
  int        hold_asks = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        rx_left = 0;
  rx_style_t rx_style = RX_STREAM;
  int        stall_cycles = 0;
  int        rand_sent = 0;

  step_row_t dir_steps [ALL_ROWS] = '{
    // fresh after reset: count 2, stack empty
    '{MODE_READ,  32'd0,          1'b1, 32'd0,          ST_OK},
    '{MODE_READ,  32'd2,          1'b1, 32'd2,          ST_RANGE},
    '{MODE_FREE,  32'd0,          1'b1, 32'd0,          ST_HEADER},
    '{MODE_FREE,  32'd2,          1'b1, 32'd2,          ST_RANGE},
    '{MODE_FREE,  32'd1,          1'b1, 32'd1,          ST_OK},
    '{MODE_ALLOC, 32'd0,          1'b1, 32'd1,          ST_OK},
    '{MODE_ALLOC, 32'hFFFF_FFFF,  1'b1, 32'd2,          ST_OK},
    '{MODE_WRITE, 32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  ST_RANGE},
    '{MODE_WRITE, 32'd0,          1'b1, 32'd0,          ST_OK},
    '{MODE_WRITE, 32'd9,          1'b1, 32'd9,          ST_OK},
    '{MODE_READ,  32'd9,          1'b1, 32'd9,          ST_OK},
    '{MODE_READ,  32'd10,         1'b1, 32'd10,         ST_RANGE},
    '{MODE_READ,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  ST_RANGE},
    // duplicate free goes on the stack twice
    '{MODE_FREE,  32'd9,          1'b1, 32'd9,          ST_OK},
    '{MODE_FREE,  32'd5,          1'b1, 32'd5,          ST_OK},
    '{MODE_FREE,  32'd9,          1'b1, 32'd9,          ST_OK},
    '{MODE_ALLOC, 32'd0,          1'b1, 32'd9,          ST_OK},
    '{MODE_ALLOC, 32'd0,          1'b1, 32'd5,          ST_OK},
    '{MODE_ALLOC, 32'd0,          1'b1, 32'd9,          ST_OK},
    '{MODE_ALLOC, 32'd0,          1'b1, 32'd10,         ST_OK},
    '{MODE_FREE,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  ST_RANGE},
    '{MODE_FREE,  32'h8000_0000,  1'b1, 32'h8000_0000,  ST_RANGE},
    '{MODE_WRITE, 32'd3,          1'b0, 32'd0,          ST_OK},
    '{MODE_READ,  32'h7FFF_FFFF,  1'b0, 32'd0,          ST_OK},
    // closing rows: stack drained, count pushed to its maximum
    '{MODE_WRITE, 32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE,  ST_OK},
    '{MODE_ALLOC, 32'd0,          1'b1, 32'd0,          ST_EXHAUSTED},
    '{MODE_READ,  32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE,  ST_OK},
    '{MODE_READ,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  ST_RANGE},
    '{MODE_FREE,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  ST_RANGE},
    '{MODE_FREE,  32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE,  ST_OK},
    '{MODE_ALLOC, 32'h1234_5678,  1'b1, 32'hFFFF_FFFE,  ST_OK},
    '{MODE_ALLOC, 32'hFFFF_FFFF,  1'b1, 32'd0,          ST_EXHAUSTED},
    '{MODE_WRITE, 32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  ST_RANGE},
    '{MODE_WRITE, 32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE,  ST_OK}
  };

  free_list_page_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model one request: pop/extend on allocate, push on free, bump on write
  function automatic out_resp_t predict_grant(input in_req_t req);
    out_resp_t resp;
    resp.granted_page = req.page_number;
    resp.status = ST_OK;
    case (mode_t'(req.mode))
      MODE_ALLOC: begin
        if (free_fill > 0) begin
          free_fill--;
          resp.granted_page = free_pages[free_fill];
        end else if (page_count == PAGE_MAX) begin
          resp.granted_page = '0;
          resp.status = ST_EXHAUSTED;
        end else begin
          resp.granted_page = page_count;
          page_count++;
        end
      end
      MODE_FREE: begin
        if (req.page_number == '0) begin
          resp.status = ST_HEADER;
        end else if (req.page_number >= page_count) begin
          resp.status = ST_RANGE;
        end else if (free_fill >= FREE_DEPTH_DEF) begin
          resp.status = ST_FULL;
        end else begin
          free_pages[free_fill] = req.page_number;
          free_fill++;
        end
      end
      MODE_WRITE: begin
        if (req.page_number == PAGE_MAX) begin
          resp.status = ST_RANGE;
        end else if (req.page_number >= page_count) begin
          page_count = req.page_number + 1'b1;
        end
      end
      default: begin
        if (req.page_number >= page_count) resp.status = ST_RANGE;
      end
    endcase
    return resp;
  endfunction

  // Mostly legal pages, some header and past-the-end, a few full-width values
  function automatic logic [PAGE_NUM_W-1:0] pick_page();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 75) return $urandom_range(page_count - 1, 1);
    else if (sel < 82) return '0;
    else if (sel < 92) return page_count + $urandom_range(3);
    else return $urandom;
  endfunction

  // Random request; writes stay near the count so range checks stay live
  function automatic in_req_t make_mix_req();
    in_req_t     req;
    int unsigned sel;
    sel = $urandom_range(99);
    req.page_number = $urandom;
    if (sel < 30) begin
      req.mode = MODE_ALLOC;
    end else if (sel < 65) begin
      req.mode = MODE_FREE;
      req.page_number = pick_page();
    end else if (sel < 80) begin
      req.mode = MODE_WRITE;
      sel = $urandom_range(99);
      if (sel < 50) req.page_number = page_count + $urandom_range(2);
      else if (sel < 80) req.page_number = $urandom_range(page_count - 1, 0);
      else if (sel < 90) req.page_number = PAGE_MAX;
      else req.page_number = '0;
    end else begin
      req.mode = MODE_READ;
      req.page_number = pick_page();
    end
    return req;
  endfunction

  // Offer one transaction in bursts with random gaps; score it on acceptance
  task automatic send_req(input in_req_t req, input logic has_exp, input out_resp_t exp_resp);
    out_resp_t model_resp;
    int        gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_resp = predict_grant(req);
    pending_grants.insert(pending_grants.size(), has_exp ? exp_resp : model_resp);
  endtask

  task automatic run_steps(input int lo, input int hi);
    in_req_t   req;
    out_resp_t exp_resp;
    for (int i = lo; i < hi; i++) begin
      req.mode = dir_steps[i].mode;
      req.page_number = dir_steps[i].page;
      exp_resp.granted_page = dir_steps[i].grant;
      exp_resp.status = dir_steps[i].status;
      send_req(req, dir_steps[i].has_exp, exp_resp);
    end
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    in_req_t req;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    run_steps(0, HEAD_ROWS);

    // random mix, with a long output hold-off early on
    for (int i = 0; i < MIX_A_ITEMS; i++) begin
      if (i == 150) hold_asks++;
      send_req(make_mix_req(), 1'b0, '0);
      rand_sent++;
    end
    pause_until_drained();

    // fill the free stack, then keep freeing into a full stack
    req.mode = MODE_FREE;
    while (free_fill < FREE_DEPTH_DEF) begin
      req.page_number = $urandom_range(page_count - 1, 1);
      send_req(req, 1'b0, '0);
      rand_sent++;
    end
    for (int i = 0; i < 16; i++) begin
      req.page_number = $urandom_range(page_count - 1, 1);
      send_req(req, 1'b0, '0);
      rand_sent++;
    end

    // more mix until the random budget is used
    while (rand_sent < RANDOM_ITEMS) begin
      if (rand_sent == RANDOM_ITEMS - 40) hold_asks++;
      send_req(make_mix_req(), 1'b0, '0);
      rand_sent++;
    end

    // empty the stack so the exhaustion rows see allocate from the count
    req.mode = MODE_ALLOC;
    while (free_fill > 0) begin
      req.page_number = $urandom;
      send_req(req, 1'b0, '0);
    end
    run_steps(HEAD_ROWS, ALL_ROWS);

    pause_until_drained();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Output throttle: styled stretches plus requested long hold-offs
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style = rx_style_t'($urandom_range(2));
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_style)
        RX_STREAM: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(1));
        default:   out_ready <= (rx_left % 4 != 0);
      endcase
    end
  end

  // Result scoreboard
  always @(posedge clk) begin
    out_resp_t exp_resp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result, actual granted_page=%h status=%0d",
                 $time, out_data.granted_page, out_data.status);
        errors++;
      end else begin
        exp_resp = pending_grants.pop_front();
        if (out_data.granted_page !== exp_resp.granted_page) begin
          $display("%0t: granted_page mismatch, expected %h actual %h",
                   $time, exp_resp.granted_page, out_data.granted_page);
          errors++;
        end
        if (out_data.status !== exp_resp.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_resp.status, out_data.status);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule

[files.f]
rtl/flpa_pkg.sv
rtl/flpa_stack_mem.sv
rtl/flpa_ctrl.sv
rtl/free_list_page_allocator.sv
tb/free_list_page_allocator_tb.sv
